### src/msrc_pkg.sv
// ---------------------------------------------------------------------------
// Motor speed ramp controller package
// Word layouts, register indexes and fixed constants shared by the ramp
// controller modules and its channel interfaces.
// ---------------------------------------------------------------------------
package msrc_pkg;

  // Speed values are in hundredths of a percent.
  localparam logic [13:0] SPEED_CEIL = 14'd10100;
  localparam logic [13:0] JUMP_SPEED = 14'd1100;
  localparam logic [13:0] BRAKE_EDGE = 14'd999;
  localparam logic [13:0] DRIVE_EDGE = 14'd900;

  // Command clamping and scaling.
  localparam logic [7:0]  CMD_MAX   = 8'd85;
  localparam logic [7:0]  CMD_MIN   = 8'd12;
  localparam logic [13:0] CMD_SCALE = 14'd100;

  // Feedback band within which the motor counts as stalled.
  localparam logic signed [15:0] STALL_BAND = 16'sd4;

  // Deceleration multipliers under a speed limit and during a forced stop.
  localparam logic [16:0] LIMIT_DECEL_MUL = 17'd6;
  localparam logic [16:0] STOP_DECEL_MUL  = 17'd100;

  // Division by 100 as a multiplication by a reciprocal: exact below 43690.
  localparam logic [26:0] DUTY_RECIP = 27'd5243;
  localparam int          DUTY_SHIFT = 19;

  // Register reset values.
  localparam logic [13:0] ACCEL_RESET = 14'd10;
  localparam logic [9:0]  DECEL_RESET = 10'd10;

  // Direction codes.
  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_REV = 1'b1;

  typedef enum logic [1:0] {
    REG_ACCEL_STEP = 2'd0,
    REG_DECEL_STEP = 2'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    DRIVE_OFF = 2'd0,
    DRIVE_FWD = 2'd1,
    DRIVE_REV = 2'd2
  } drive_mode_t;

  // Configuration write word.
  typedef struct packed {
    logic [1:0]  index;
    logic [13:0] value;
  } cfg_word_t;

  // Current register contents.
  typedef struct packed {
    logic [13:0] accel_step;
    logic [9:0]  decel_step;
  } cfg_regs_t;

  // One control tick.
  typedef struct packed {
    logic signed [7:0]  command_speed;
    logic signed [15:0] feedback_speed;
    logic [15:0]        stop_hold_load;
    logic               limit_load;
    logic [13:0]        limit_value;
    logic [15:0]        limit_hold_ticks;
  } in_word_t;

  // Result of the ramp update, before the duty is derived.
  typedef struct packed {
    logic [13:0]       speed;
    logic              direction;
    logic              brake_open;
    drive_mode_t       drive_mode;
    logic signed [7:0] clamped_command;
  } ramp_word_t;

  // One result word.
  typedef struct packed {
    logic [6:0]        pwm_duty;
    logic signed [7:0] signed_speed;
    logic              brake_open;
    logic [1:0]        drive_mode;
    logic signed [7:0] clamped_command;
  } out_word_t;

endpackage

### src/msrc_stream_if.sv
// ---------------------------------------------------------------------------
// Motor speed ramp controller channel
// Valid/ready channel carrying one word of the given type.
// ---------------------------------------------------------------------------
interface msrc_stream_if #(
  parameter type word_t = logic
) ();

  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

### src/motor_speed_ramp_controller.sv
// ---------------------------------------------------------------------------
// Motor speed ramp controller
// Slew-rate limited motor speed ramp with timed speed limit, forced stop and
// direction reversal, one update per control tick.
// ---------------------------------------------------------------------------
// Usage:
//   in_stream carries one control tick per word: command, feedback speed and
//   the optional limit and forced-stop loads. out_stream returns exactly one
//   word per tick, in order: duty, signed speed, brake, drive mode and the
//   clamped command. cfg writes the acceleration step (index 0) and the
//   deceleration step (index 1); it is always ready and should only be used
//   while no tick is in flight.
//   A tick passes an input register, the ramp update with its result register
//   and the duty register. One tick is taken every cycle while the receiver
//   keeps out_stream.ready high; the rate is set by the speed update loop.
//   Reset clears the speed to zero in the forward direction, sets the limit
//   to full scale, clears both hold counters, sets both steps to 10 and
//   empties the pipeline. When the receiver stalls, the three registers fill
//   and in_stream.ready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module motor_speed_ramp_controller (
  input  logic          clk,
  input  logic          rst,
  msrc_stream_if.sink   cfg,
  msrc_stream_if.sink   in_stream,
  msrc_stream_if.source out_stream
);
  import msrc_pkg::*;

  cfg_regs_t regs;

  msrc_stream_if #(.word_t(ramp_word_t)) link ();

  msrc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  msrc_ramp u_ramp (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .in_stream (in_stream),
    .link      (link)
  );

  msrc_duty u_duty (
    .clk        (clk),
    .rst        (rst),
    .link       (link),
    .out_stream (out_stream)
  );

endmodule

### src/msrc_cfg_regs.sv
// ---------------------------------------------------------------------------
// Motor speed ramp controller configuration registers
// Holds the acceleration and deceleration steps; writes to unknown indexes
// are taken and ignored.
// ---------------------------------------------------------------------------
module msrc_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  msrc_stream_if.sink         cfg,
  output msrc_pkg::cfg_regs_t regs
);
  import msrc_pkg::*;

  logic [13:0] accel_step;
  logic [9:0]  decel_step;

  // The register file never stalls a write.
  assign cfg.ready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_step <= ACCEL_RESET;
      decel_step <= DECEL_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_ACCEL_STEP: accel_step <= cfg.data.value;
        REG_DECEL_STEP: decel_step <= cfg.data.value[9:0];
        default: ;
      endcase
    end
  end

  assign regs.accel_step = accel_step;
  assign regs.decel_step = decel_step;

endmodule

### src/msrc_ramp.sv
// ---------------------------------------------------------------------------
// Motor speed ramp controller ramp stage
// Input register followed by the per-tick state update: counter loads, stall
// detection, target selection, slew limiting and direction reversal.
// ---------------------------------------------------------------------------
module msrc_ramp (
  input  logic                clk,
  input  logic                rst,
  input  msrc_pkg::cfg_regs_t regs,
  msrc_stream_if.sink         in_stream,
  msrc_stream_if.source       link
);
  import msrc_pkg::*;

  // Input register.
  logic     q_valid;
  in_word_t q_item;
  logic     q_take;

  // Result register towards the duty stage.
  logic       r_valid;
  ramp_word_t r_word;
  ramp_word_t r_word_next;

  // Controller state.
  logic [13:0] current_speed;
  logic [13:0] current_speed_next;
  logic        current_direction;
  logic        current_direction_next;
  logic [13:0] speed_limit;
  logic [13:0] speed_limit_next;
  logic [15:0] limit_hold_count;
  logic [15:0] limit_hold_count_next;
  logic [15:0] stop_hold_count;
  logic [15:0] stop_hold_count_next;

  // Update terms.
  logic        want_dir;
  logic [7:0]  cmd_mag;
  logic [6:0]  mag_clamped;
  logic [13:0] want_speed;
  logic [13:0] limit_loaded;
  logic [15:0] limit_count_loaded;
  logic [15:0] stop_count_loaded;
  logic        stall;
  logic [13:0] target;
  logic [14:0] up;
  logic [16:0] down;
  logic [14:0] up_sum;
  logic [13:0] up_speed;
  logic [16:0] target_plus_down;

  // Handshake: the input register drains whenever the result register frees.
  assign q_take          = q_valid && (!r_valid || link.ready);
  assign in_stream.ready = !q_valid || !r_valid || link.ready;
  assign link.valid      = r_valid;
  assign link.data       = r_word;

  // Command magnitude, clamping and scaling.
  always_comb begin
    want_dir = q_item.command_speed[7];
    cmd_mag  = want_dir ? (8'd0 - $unsigned(q_item.command_speed))
                        : $unsigned(q_item.command_speed);
    if (cmd_mag >= CMD_MAX) begin
      mag_clamped = CMD_MAX[6:0];
    end else if (cmd_mag < CMD_MIN) begin
      mag_clamped = 7'd0;
    end else begin
      mag_clamped = cmd_mag[6:0];
    end
    want_speed = 14'(mag_clamped) * CMD_SCALE;
  end

  // Loads, limit timer, target and step selection.
  always_comb begin
    stop_count_loaded  = (q_item.stop_hold_load != 16'd0) ? q_item.stop_hold_load
                                                          : stop_hold_count;
    limit_loaded       = speed_limit;
    limit_count_loaded = limit_hold_count;
    if (q_item.limit_load) begin
      limit_loaded       = (q_item.limit_value > SPEED_CEIL) ? SPEED_CEIL
                                                             : q_item.limit_value;
      limit_count_loaded = q_item.limit_hold_ticks;
    end

    // Stall is judged against the direction held before this tick.
    if (current_direction == DIR_REV) begin
      stall = $signed(q_item.feedback_speed) > -STALL_BAND;
    end else begin
      stall = $signed(q_item.feedback_speed) < STALL_BAND;
    end

    if (limit_count_loaded != 16'd0) begin
      limit_hold_count_next = limit_count_loaded - 16'd1;
      speed_limit_next      = limit_loaded;
    end else begin
      limit_hold_count_next = 16'd0;
      speed_limit_next      = SPEED_CEIL;
    end

    if (want_speed >= speed_limit_next) begin
      target = speed_limit_next;
      up     = 15'(regs.accel_step >> 1);
      down   = 17'(regs.decel_step) * LIMIT_DECEL_MUL;
      if (speed_limit_next == 14'd0) begin
        stall = 1'b1;
      end
    end else begin
      target = want_speed;
      up     = 15'(regs.accel_step);
      down   = 17'(regs.decel_step);
    end

    // A pending forced stop overrides the target.
    stop_hold_count_next = stop_count_loaded;
    if (stop_count_loaded != 16'd0) begin
      stop_hold_count_next = stop_count_loaded - 16'd1;
      target               = 14'd0;
      down                 = 17'(regs.decel_step) * STOP_DECEL_MUL;
    end
  end

  // Speed and direction update.
  always_comb begin
    up_sum           = 15'(current_speed) + up;
    up_speed         = (up_sum > 15'(target)) ? target : up_sum[13:0];
    target_plus_down = 17'(target) + down;
    if (up_speed < JUMP_SPEED) begin
      up_speed = JUMP_SPEED;
    end

    current_speed_next     = current_speed;
    current_direction_next = current_direction;
    if (want_dir != current_direction) begin
      // Reversal: slow down, then restart in the new direction once stalled.
      if (stall) begin
        current_speed_next     = JUMP_SPEED;
        current_direction_next = want_dir;
      end else if (17'(current_speed) > down) begin
        current_speed_next = 14'(17'(current_speed) - down);
      end else begin
        current_speed_next = 14'd0;
      end
    end else if (target > current_speed) begin
      current_speed_next = up_speed;
    end else if (target != current_speed) begin
      if (target_plus_down >= 17'(current_speed)) begin
        current_speed_next = target;
      end else begin
        current_speed_next = 14'(17'(current_speed) - down);
      end
    end
  end

  // Brake, drive mode and clamped command for the result word.
  always_comb begin
    r_word_next.speed     = current_speed_next;
    r_word_next.direction = current_direction_next;
    if (current_speed_next > BRAKE_EDGE) begin
      r_word_next.brake_open = 1'b1;
    end else if (!stall) begin
      r_word_next.brake_open = (limit_hold_count_next == 16'd0);
    end else begin
      r_word_next.brake_open = 1'b0;
    end
    if (current_speed_next < DRIVE_EDGE) begin
      r_word_next.drive_mode = DRIVE_OFF;
    end else if (current_direction_next == DIR_REV) begin
      r_word_next.drive_mode = DRIVE_REV;
    end else begin
      r_word_next.drive_mode = DRIVE_FWD;
    end
    r_word_next.clamped_command = want_dir ? $signed(8'd0 - 8'(mag_clamped))
                                           : $signed(8'(mag_clamped));
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_stream.valid && in_stream.ready) begin
      q_valid <= 1'b1;
    end else if (q_take) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.valid && in_stream.ready) begin
      q_item <= in_stream.data;
    end
  end

  // State and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid           <= 1'b0;
      current_speed     <= 14'd0;
      current_direction <= DIR_FWD;
      speed_limit       <= SPEED_CEIL;
      limit_hold_count  <= 16'd0;
      stop_hold_count   <= 16'd0;
    end else if (q_take) begin
      r_valid           <= 1'b1;
      current_speed     <= current_speed_next;
      current_direction <= current_direction_next;
      speed_limit       <= speed_limit_next;
      limit_hold_count  <= limit_hold_count_next;
      stop_hold_count   <= stop_hold_count_next;
    end else if (link.ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      r_word <= r_word_next;
    end
  end

endmodule

### src/msrc_duty.sv
// ---------------------------------------------------------------------------
// Motor speed ramp controller duty stage
// Converts the speed in hundredths to a duty percent and holds the result
// word for the receiver.
// ---------------------------------------------------------------------------
module msrc_duty (
  input  logic          clk,
  input  logic          rst,
  msrc_stream_if.sink   link,
  msrc_stream_if.source out_stream
);
  import msrc_pkg::*;

  logic        o_valid;
  out_word_t   o_word;
  logic [26:0] duty_product;
  logic [6:0]  duty;
  logic        link_take;

  assign link.ready       = !o_valid || out_stream.ready;
  assign link_take        = link.valid && link.ready;
  assign out_stream.valid = o_valid;
  assign out_stream.data  = o_word;

  // Speed divided by 100 through the reciprocal.
  always_comb begin
    duty_product = 27'(link.data.speed) * DUTY_RECIP;
    duty         = duty_product[DUTY_SHIFT +: 7];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (link_take) begin
      o_valid <= 1'b1;
    end else if (out_stream.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (link_take) begin
      o_word.pwm_duty        <= duty;
      o_word.signed_speed    <= (link.data.direction == DIR_REV)
                                ? $signed(8'd0 - 8'(duty)) : $signed(8'(duty));
      o_word.brake_open      <= link.data.brake_open;
      o_word.drive_mode      <= link.data.drive_mode;
      o_word.clamped_command <= link.data.clamped_command;
    end
  end

endmodule
